FILE: hw/rtl/mcc2d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcc2d_pkg
// Shared types and constants of the multi-channel 2D convolution block.
// ----------------------------------------------------------------------------
package mcc2d_pkg;

   localparam logic [1:0] ACT_WEIGHT = 2'd0;
   localparam logic [1:0] ACT_BIAS   = 2'd1;
   localparam logic [1:0] ACT_SAMPLE = 2'd2;
   localparam logic [1:0] ACT_NOP    = 2'd3;

   localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd0;
   localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd1;
   localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
   localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd3;
   localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd4;
   localparam logic [2:0] REG_KERNEL_COUNT  = 3'd5;

   localparam int CSR_DATA_W = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int ACC_W      = 48;

   typedef struct packed {
      logic [1:0]         action;
      logic               frame_start;
      logic [2:0]         tap_row;
      logic [2:0]         tap_col;
      logic [3:0]         tap_channel;
      logic [4:0]         kernel_index;
      logic signed [15:0] weight_value;
      logic signed [31:0] bias_value;
      logic signed [15:0] sample_value;
   } req_type;

   typedef struct packed {
      logic [6:0]         out_row;
      logic [6:0]         out_col;
      logic [4:0]         out_kernel;
      logic signed [31:0] result_value;
      logic               last_of_run;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic clr;    // start of a kernel: clear accumulator
      logic mac;    // tap read issued this cycle
      logic fin;    // accumulator complete, build result
   } cmd_type;

endpackage
`default_nettype wire

FILE: hw/rtl/mcc2d_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcc2d_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface mcc2d_if #(parameter type T = logic);
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/mcc2d_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcc2d_dp
// Datapath: one registered MAC on the weight/line memory read data, then
// arithmetic right shift, bias add and saturation.
// ----------------------------------------------------------------------------
module mcc2d_dp (
   input  wire                        clock,
   input  wire mcc2d_pkg::cmd_type    cmd,
   input  wire logic signed [15:0]    wdata,
   input  wire logic signed [15:0]    ldata,
   input  wire logic signed [31:0]    bias,
   output logic signed [31:0]         result
);
   logic                                 mv_ff;
   logic                                 fin_d_ff;
   logic signed [31:0]                   prod_ff;
   logic signed [mcc2d_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [mcc2d_pkg::ACC_W-1:0]  sh;
   logic signed [mcc2d_pkg::ACC_W:0]    sum;

   // mac delayed via mv_ff, mv2_ff: memory read data is registered, then the product
   logic mv2_ff;
   always_ff @(posedge clock) begin
      mv_ff    <= cmd.mac;
      mv2_ff   <= mv_ff;
      prod_ff  <= wdata * ldata;
      fin_d_ff <= cmd.fin;
      acc_ff   <= acc_in;
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.clr) acc_in = '0;
      else if (mv2_ff)
         acc_in = acc_ff + mcc2d_pkg::ACC_W'(prod_ff);
   end

   assign sh  = acc_ff >>> 14;
   assign sum = (mcc2d_pkg::ACC_W+1)'(sh) + (mcc2d_pkg::ACC_W+1)'(bias);

   always_comb begin
      if (sum > 49'sd2147483647)       result = 32'sh7FFFFFFF;
      else if (sum < -49'sd2147483648) result = 32'sh80000000;
      else                             result = sum[31:0];
   end

   logic unused_ok;
   assign unused_ok = fin_d_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/mcc2d_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcc2d_ctrl
// Controller: config, position counters, stores, and tap sequencing.
// ----------------------------------------------------------------------------
module mcc2d_ctrl #(
   parameter int MAX_IMAGE_WIDTH  = 128,
   parameter int MAX_IMAGE_HEIGHT = 128,
   parameter int MAX_CHANNELS     = 16,
   parameter int MAX_KERNEL_SIDE  = 5,
   parameter int MAX_KERNELS      = 32
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_we,
   input  wire [2:0]               csr_index,
   input  wire [7:0]               csr_wdata,
   input  wire                     in_valid,
   output logic                    in_ready,
   input  wire mcc2d_pkg::req_type in_data,
   output logic                    out_valid,
   input  wire                     out_ready,
   output mcc2d_pkg::rsp_type      out_data,
   output mcc2d_pkg::cmd_type      cmd,
   output logic signed [15:0]      wdata,
   output logic signed [15:0]      ldata,
   output logic signed [31:0]      bias,
   input  wire logic signed [31:0] result
);
   localparam int SW = (MAX_KERNEL_SIDE > 1) ? $clog2(MAX_KERNEL_SIDE) : 1;
   localparam int KW = (MAX_KERNELS > 1) ? $clog2(MAX_KERNELS) : 1;
   localparam int XW = (MAX_IMAGE_WIDTH > 1) ? $clog2(MAX_IMAGE_WIDTH) : 1;
   localparam int LD = MAX_KERNEL_SIDE * MAX_IMAGE_WIDTH * MAX_CHANNELS;
   localparam int WD = MAX_KERNELS * MAX_KERNEL_SIDE * MAX_KERNEL_SIDE * MAX_CHANNELS;
   localparam int LAW = (LD > 1) ? $clog2(LD) : 1;
   localparam int WAW = (WD > 1) ? $clog2(WD) : 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RUN  = 3'd1;
   localparam logic [2:0] S_WAIT = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [7:0] ih_ff, iw_ff;
   logic [4:0] cc_ff;
   logic [2:0] kh_ff, kw_ff;
   logic [5:0] kc_ff;
   logic [7:0] row_ff, col_ff;
   logic [4:0] ch_ff;
   logic [SW-1:0] rs_ff, r0s_ff;

   logic signed [15:0] line_mem [LD];
   logic signed [15:0] wt_mem   [WD];
   logic signed [31:0] bias_mem [MAX_KERNELS];

   logic [7:0] r0_ff, c0_ff;
   logic [5:0] k_ff;
   logic [2:0] ky_ff, kx_ff;
   logic [4:0] c_ff;
   logic [2:0] wait_ff;
   mcc2d_pkg::rsp_type rsp_ff;
   logic rv_ff;

   function automatic logic [7:0] clampv(input logic [7:0] v, input int lim);
      logic [7:0] r;
      r = v;
      if (v == 8'd0) r = 8'd1;
      else if (32'(v) > lim) r = 8'(lim);
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         ih_ff <= clampv(8'd32, MAX_IMAGE_HEIGHT);
         iw_ff <= clampv(8'd32, MAX_IMAGE_WIDTH);
         cc_ff <= 5'(clampv(8'd1, MAX_CHANNELS));
         kh_ff <= 3'(clampv(8'd3, MAX_KERNEL_SIDE));
         kw_ff <= 3'(clampv(8'd3, MAX_KERNEL_SIDE));
         kc_ff <= 6'(clampv(8'd1, MAX_KERNELS));
      end else if (csr_we) begin
         unique case (csr_index)
            mcc2d_pkg::REG_IMAGE_HEIGHT:  ih_ff <= clampv(csr_wdata, MAX_IMAGE_HEIGHT);
            mcc2d_pkg::REG_IMAGE_WIDTH:   iw_ff <= clampv(csr_wdata, MAX_IMAGE_WIDTH);
            mcc2d_pkg::REG_CHANNEL_COUNT:
               cc_ff <= 5'(clampv({3'd0, csr_wdata[4:0]}, MAX_CHANNELS));
            mcc2d_pkg::REG_KERNEL_HEIGHT:
               kh_ff <= 3'(clampv({5'd0, csr_wdata[2:0]}, MAX_KERNEL_SIDE));
            mcc2d_pkg::REG_KERNEL_WIDTH:
               kw_ff <= 3'(clampv({5'd0, csr_wdata[2:0]}, MAX_KERNEL_SIDE));
            mcc2d_pkg::REG_KERNEL_COUNT:
               kc_ff <= 6'(clampv({2'd0, csr_wdata[5:0]}, MAX_KERNELS));
            default: ;
         endcase
      end
   end

   logic acc;
   assign in_ready = (state_ff == S_IDLE);
   assign acc = in_valid && in_ready;

   logic [7:0] rp, cp;
   logic [4:0] chp;
   logic       in_rng, fire;
   assign rp  = in_data.frame_start ? 8'd0 : row_ff;
   assign cp  = in_data.frame_start ? 8'd0 : col_ff;
   assign chp = in_data.frame_start ? 5'd0 : ch_ff;
   assign in_rng = (rp < ih_ff) && (cp < iw_ff) && (chp < cc_ff);
   assign fire = (chp + 5'd1 == cc_ff) && (9'(rp) + 9'd1 >= 9'(kh_ff))
              && (9'(cp) + 9'd1 >= 9'(kw_ff));
   logic smp;
   assign smp = acc && (in_data.action == mcc2d_pkg::ACT_SAMPLE) && in_rng;

   // line buffer row slots: row number modulo the maximum kernel side, kept incrementally
   logic [SW-1:0] rsl, rs_nx, r0s, ys;
   logic [SW:0]   r0t, yt;
   assign rsl   = in_data.frame_start ? '0 : rs_ff;
   assign rs_nx = (rsl == SW'(MAX_KERNEL_SIDE - 1)) ? '0 : rsl + SW'(1);
   assign r0t   = {1'b0, rsl} + (SW+1)'(MAX_KERNEL_SIDE + 1) - (SW+1)'(kh_ff);
   assign r0s   = (r0t >= (SW+1)'(MAX_KERNEL_SIDE))
                ? SW'(r0t - (SW+1)'(MAX_KERNEL_SIDE)) : r0t[SW-1:0];
   assign yt    = {1'b0, r0s_ff} + (SW+1)'(ky_ff);
   assign ys    = (yt >= (SW+1)'(MAX_KERNEL_SIDE))
                ? SW'(yt - (SW+1)'(MAX_KERNEL_SIDE)) : yt[SW-1:0];

   // line address
   function automatic logic [LAW-1:0] laddr(input logic [SW-1:0] s, input logic [7:0] c,
                                            input logic [4:0] ch);
      logic [LAW+7:0] a;
      a = ((LAW+8)'(s) * (LAW+8)'(MAX_IMAGE_WIDTH) + (LAW+8)'(c))
          * (LAW+8)'(MAX_CHANNELS) + (LAW+8)'(ch);
      return a[LAW-1:0];
   endfunction
   function automatic logic [WAW-1:0] waddr(input logic [5:0] k, input logic [2:0] r,
                                            input logic [2:0] c, input logic [4:0] ch);
      logic [WAW+7:0] a;
      a = ((((WAW+8)'(k) * (WAW+8)'(MAX_KERNEL_SIDE) + (WAW+8)'(r))
           * (WAW+8)'(MAX_KERNEL_SIDE) + (WAW+8)'(c)) * (WAW+8)'(MAX_CHANNELS))
          + (WAW+8)'(ch);
      return a[WAW-1:0];
   endfunction

   logic wld;
   assign wld = acc && (in_data.action == mcc2d_pkg::ACT_WEIGHT)
      && (32'(in_data.tap_row) < MAX_KERNEL_SIDE) && (32'(in_data.tap_col) < MAX_KERNEL_SIDE)
      && (32'(in_data.tap_channel) < MAX_CHANNELS) && (32'(in_data.kernel_index) < MAX_KERNELS);

   logic [7:0] cx;
   assign cx = c0_ff + 8'(kx_ff);

   always_ff @(posedge clock) begin
      if (smp) line_mem[laddr(rsl, cp, chp)] <= in_data.sample_value;
      if (wld)
         wt_mem[waddr({1'b0, in_data.kernel_index}, in_data.tap_row, in_data.tap_col,
                      {1'b0, in_data.tap_channel})] <= in_data.weight_value;
      if (acc && in_data.action == mcc2d_pkg::ACT_BIAS
          && 32'(in_data.kernel_index) < MAX_KERNELS)
         bias_mem[in_data.kernel_index[KW-1:0]] <= in_data.bias_value;
      ldata <= line_mem[laddr(ys, cx, c_ff)];
      wdata <= wt_mem[waddr(k_ff, ky_ff, kx_ff, c_ff)];
      bias  <= bias_mem[k_ff[KW-1:0]];
   end

   logic last_tap;
   assign last_tap = (c_ff + 5'd1 == cc_ff) && (kx_ff + 3'd1 == kw_ff)
                  && (ky_ff + 3'd1 == kh_ff);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: if (smp && fire) begin
            state_in = S_RUN;
            cmd.clr = 1'b1;
         end
         S_RUN: begin
            cmd.mac = 1'b1;
            if (last_tap) state_in = S_WAIT;
         end
         S_WAIT: if (wait_ff == 3'd2) state_in = S_FIN;
         S_FIN: begin
            cmd.fin = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: if (out_ready) begin
            if (k_ff + 6'd1 == kc_ff) state_in = S_IDLE;
            else begin
               state_in = S_RUN;
               cmd.clr = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff <= '0; col_ff <= '0; ch_ff <= '0; rs_ff <= '0;
         rv_ff <= 1'b0;
         k_ff <= '0; ky_ff <= '0; kx_ff <= '0; c_ff <= '0; wait_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (smp) begin
            r0_ff <= rp + 8'd1 - 8'(kh_ff);
            c0_ff <= cp + 8'd1 - 8'(kw_ff);
            r0s_ff <= r0s;
            k_ff <= '0; ky_ff <= '0; kx_ff <= '0; c_ff <= '0;
            if (chp + 5'd1 >= cc_ff) begin
               ch_ff <= '0;
               if (cp + 8'd1 >= iw_ff) begin
                  col_ff <= '0;
                  row_ff <= rp + 8'd1;
                  rs_ff <= rs_nx;
               end else begin
                  col_ff <= cp + 8'd1;
                  row_ff <= rp;
                  rs_ff <= rsl;
               end
            end else begin
               ch_ff <= chp + 5'd1;
               col_ff <= cp;
               row_ff <= rp;
               rs_ff <= rsl;
            end
         end else if (acc && in_data.action == mcc2d_pkg::ACT_SAMPLE
                      && in_data.frame_start) begin
            row_ff <= '0; col_ff <= '0; ch_ff <= '0; rs_ff <= '0;
         end
         if (state_ff == S_RUN) begin
            wait_ff <= '0;
            if (c_ff + 5'd1 < cc_ff) c_ff <= c_ff + 5'd1;
            else begin
               c_ff <= '0;
               if (kx_ff + 3'd1 < kw_ff) kx_ff <= kx_ff + 3'd1;
               else begin
                  kx_ff <= '0;
                  if (ky_ff + 3'd1 < kh_ff) ky_ff <= ky_ff + 3'd1;
                  else ky_ff <= '0;
               end
            end
         end
         if (state_ff == S_WAIT) wait_ff <= wait_ff + 3'd1;
         if (cmd.fin) begin
            rv_ff <= 1'b1;
            rsp_ff.out_row <= r0_ff[6:0];
            rsp_ff.out_col <= c0_ff[6:0];
            rsp_ff.out_kernel <= k_ff[4:0];
            rsp_ff.result_value <= result;
            rsp_ff.last_of_run <= (k_ff + 6'd1 == kc_ff);
         end
         if (state_ff == S_OUT && out_ready) begin
            rv_ff <= 1'b0;
            k_ff <= k_ff + 6'd1;
         end
      end
   end

   assign out_valid = rv_ff;
   assign out_data  = rsp_ff;

   logic unused_ok;
   assign unused_ok = ^{XW, MAX_IMAGE_HEIGHT};
endmodule
`default_nettype wire

FILE: hw/rtl/multichannel_conv2d_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_conv2d_top
// Valid multi-channel 2D convolution with per-kernel bias.
// ----------------------------------------------------------------------------
// Weight and bias loads are written straight into their memories. An image
// sample that completes a window starts one single-MAC run per kernel: the
// taps over kernel rows, kernel columns and channels are read from the weight
// and line memories, the pipeline drains and the result is held until it is
// taken. Input is held off until the last kernel's result is transferred.
// ----------------------------------------------------------------------------
module multichannel_conv2d_top #(
   parameter int MAX_IMAGE_WIDTH  = 128,
   parameter int MAX_IMAGE_HEIGHT = 128,
   parameter int MAX_CHANNELS     = 16,
   parameter int MAX_KERNEL_SIDE  = 5,
   parameter int MAX_KERNELS      = 32
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        csr_we,
   input  wire [2:0]  csr_index,
   input  wire [7:0]  csr_wdata,
   mcc2d_if.sink      req,
   mcc2d_if.source    rsp
);
   mcc2d_pkg::cmd_type cmd;
   logic signed [15:0] wdata, ldata;
   logic signed [31:0] bias, result;

   mcc2d_ctrl #(
      .MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH), .MAX_IMAGE_HEIGHT(MAX_IMAGE_HEIGHT),
      .MAX_CHANNELS(MAX_CHANNELS), .MAX_KERNEL_SIDE(MAX_KERNEL_SIDE),
      .MAX_KERNELS(MAX_KERNELS)
   ) u_ctrl (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data),
      .cmd(cmd), .wdata(wdata), .ldata(ldata), .bias(bias), .result(result)
   );

   mcc2d_dp u_dp (
      .clock(clock), .cmd(cmd), .wdata(wdata), .ldata(ldata),
      .bias(bias), .result(result)
   );
endmodule
`default_nettype wire
